@@ rtl/shp_pkg.sv @@
// ----------------------------------------------------------------------------
// Half-step positioner package
// Shared types, operation codes and constants for the half-step stepper
// positioner.
// ----------------------------------------------------------------------------
package shp_pkg;

	// Operation codes carried in the opcode field of a request.
	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_SET_SPEED  = 3'd1;
	localparam logic [2:0] OP_ADD_SPEED  = 3'd2;
	localparam logic [2:0] OP_SUB_SPEED  = 3'd3;
	localparam logic [2:0] OP_SET_TARGET = 3'd4;
	localparam logic [2:0] OP_ADD_TARGET = 3'd5;
	localparam logic [2:0] OP_SUB_TARGET = 3'd6;

	// Configuration register indexes.
	localparam logic CFG_MAX_SPEED  = 1'b0;
	localparam logic CFG_MAX_TARGET = 1'b1;

	// Delay that corresponds to standstill; speed is this minus the step delay.
	localparam logic [12:0] FULL_DELAY       = 13'd5500;
	localparam logic [12:0] RESET_DELAY      = 13'd3000;
	localparam logic [12:0] RESET_MAX_SPEED  = 13'd3500;
	localparam logic [15:0] RESET_MAX_TARGET = 16'd1400;
	localparam logic [3:0]  COILS_OFF        = 4'h0;

	// One request: an operation and its amount.
	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] operand;
	} shp_in_t;

	// One result: the state after the request plus per-request flags.
	typedef struct packed {
		logic [3:0]  coil_pattern;
		logic        motor_on;
		logic [15:0] position_now;
		logic [15:0] position_goal;
		logic [12:0] speed_now;
		logic        clamped;
		logic        arrived;
	} shp_out_t;

	// Architectural state of the positioner.
	typedef struct packed {
		logic [2:0]  phase_index;
		logic [15:0] position;
		logic [15:0] target;
		logic [12:0] step_delay;
		logic [12:0] delay_counter;
		logic [3:0]  coil;
		logic        motor_active;
	} shp_state_t;

	localparam shp_state_t STATE_RESET = '{
		phase_index:   3'd0,
		position:      16'd0,
		target:        16'd0,
		step_delay:    RESET_DELAY,
		delay_counter: 13'd0,
		coil:          COILS_OFF,
		motor_active:  1'b0
	};

	// Half-step coil sequence, A in bit 0 through D in bit 3.
	function automatic logic [3:0] half_step_coils(input logic [2:0] phase);
		logic [3:0] coils;
		case (phase)
			3'd0:    coils = 4'h1;
			3'd1:    coils = 4'h3;
			3'd2:    coils = 4'h2;
			3'd3:    coils = 4'h6;
			3'd4:    coils = 4'h4;
			3'd5:    coils = 4'hC;
			3'd6:    coils = 4'h8;
			default: coils = 4'h9;
		endcase
		return coils;
	endfunction

endpackage

@@ rtl/shp_next.sv @@
// ----------------------------------------------------------------------------
// Half-step positioner update logic
// Computes the next state and the result of one request from the current
// state and the limit registers.
// ----------------------------------------------------------------------------
module shp_next (
	input  shp_pkg::shp_state_t state,
	input  logic [12:0]         max_speed,
	input  logic [15:0]         max_target,
	input  shp_pkg::shp_in_t    cmd,
	output shp_pkg::shp_state_t state_next,
	output shp_pkg::shp_out_t   rsp
);
	import shp_pkg::*;

	logic [12:0] speed_lim;
	logic [12:0] speed_cur;
	logic [16:0] speed_want;
	logic        speed_clip;
	logic [12:0] speed_new;
	logic [16:0] target_want;
	logic        target_clip;
	logic [15:0] target_new;
	logic [2:0]  phase_up;
	logic [2:0]  phase_dn;

	// Effective speed limit and the current speed.
	assign speed_lim = (max_speed > FULL_DELAY) ? FULL_DELAY : max_speed;
	assign speed_cur = FULL_DELAY - state.step_delay;

	// Requested speed before saturation.
	always_comb begin
		case (cmd.opcode)
			OP_ADD_SPEED: speed_want = {4'd0, speed_cur} + {1'b0, cmd.operand};
			OP_SUB_SPEED: speed_want = {4'd0, speed_cur} - {1'b0, cmd.operand};
			default:      speed_want = {1'b0, cmd.operand};
		endcase
	end

	assign speed_clip = speed_want > {4'd0, speed_lim};
	assign speed_new  = speed_clip ? speed_lim : speed_want[12:0];

	// Requested target before clamping.
	always_comb begin
		case (cmd.opcode)
			OP_ADD_TARGET: target_want = {1'b0, state.target} + {1'b0, cmd.operand};
			OP_SUB_TARGET: target_want = {1'b0, state.target} - {1'b0, cmd.operand};
			default:       target_want = {1'b0, cmd.operand};
		endcase
	end

	assign target_clip = target_want > {1'b0, max_target};
	assign target_new  = target_clip ? max_target : target_want[15:0];

	assign phase_up = state.phase_index + 3'd1;
	assign phase_dn = state.phase_index - 3'd1;

	// Apply the operation to the state and build the result.
	always_comb begin
		state_next  = state;
		rsp.clamped = 1'b0;
		rsp.arrived = 1'b0;
		case (cmd.opcode)
			OP_TICK: begin
				if (state.delay_counter != 13'd0) begin
					state_next.delay_counter = state.delay_counter - 13'd1;
				end else begin
					state_next.delay_counter = state.step_delay;
					if (state.target == state.position) begin
						state_next.coil         = COILS_OFF;
						state_next.motor_active = 1'b0;
						rsp.arrived             = 1'b1;
					end else if (state.target < state.position) begin
						state_next.phase_index = phase_dn;
						state_next.position    = state.position - 16'd1;
						state_next.coil        = half_step_coils(phase_dn);
					end else begin
						state_next.phase_index = phase_up;
						state_next.position    = state.position + 16'd1;
						state_next.coil        = half_step_coils(phase_up);
					end
				end
			end
			OP_SET_SPEED, OP_ADD_SPEED: begin
				state_next.step_delay = FULL_DELAY - speed_new;
				rsp.clamped           = speed_clip;
			end
			OP_SUB_SPEED: begin
				// Taking more than the current speed stops at zero speed.
				if ({3'd0, speed_cur} < cmd.operand) begin
					state_next.step_delay = FULL_DELAY;
					rsp.clamped           = 1'b1;
				end else begin
					state_next.step_delay = FULL_DELAY - speed_new;
					rsp.clamped           = speed_clip;
				end
			end
			OP_SET_TARGET, OP_ADD_TARGET: begin
				state_next.target       = target_new;
				state_next.motor_active = 1'b1;
				rsp.clamped             = target_clip;
			end
			OP_SUB_TARGET: begin
				// Taking more than the current target stops at position zero.
				state_next.motor_active = 1'b1;
				if (state.target < cmd.operand) begin
					state_next.target = 16'd0;
					rsp.clamped       = 1'b1;
				end else begin
					state_next.target = target_new;
					rsp.clamped       = target_clip;
				end
			end
			default: begin
				state_next = state;
			end
		endcase

		rsp.coil_pattern  = state_next.coil;
		rsp.motor_on      = state_next.motor_active;
		rsp.position_now  = state_next.position;
		rsp.position_goal = state_next.target;
		rsp.speed_now     = FULL_DELAY - state_next.step_delay;
	end

endmodule

@@ rtl/stepper_halfstep_positioner.sv @@
// ----------------------------------------------------------------------------
// Half-step stepper positioner
// Steps an eight-phase half-step coil sequence toward a target position at a
// programmable rate, with saturating speed and target operations.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------
//  cmd     | in        | cmd_valid, cmd_stall | shp_in_t  opcode, operand
//  rsp     | out       | rsp_valid, rsp_stall | shp_out_t coils, position...
//  cfg     | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// A request is registered in the request stage on acceptance and its result
// is loaded into the result register; one request per cycle unless stalled.
// The update of the positioner state happens in the same cycle the result is
// loaded, so back-to-back requests always see the state of their predecessor.
// A stalled result holds the request stage, which then raises cmd_stall.
// Reset is asynchronous and active low; it loads the power-on state and the
// default limits (max speed 3500, max target 1400). Configuration is always
// ready.
// ----------------------------------------------------------------------------
module stepper_halfstep_positioner (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  shp_pkg::shp_in_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output shp_pkg::shp_out_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);
	import shp_pkg::*;

	shp_in_t    cmd_s1;
	logic       valid_s1;
	shp_state_t state_q;
	shp_state_t state_next;
	shp_out_t   rsp_next;
	shp_out_t   rsp_q;
	logic       rsp_valid_q;
	logic [12:0] max_speed_q;
	logic [15:0] max_target_q;
	logic       advance;

	// The request stage moves on whenever the result register is empty or not stalled.
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	// Request stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cmd;
		end
	end

	// Limit registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q  <= RESET_MAX_SPEED;
			max_target_q <= RESET_MAX_TARGET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MAX_SPEED:  max_speed_q  <= cfg_data[12:0];
				CFG_MAX_TARGET: max_target_q <= cfg_data;
				default:        max_target_q <= max_target_q;
			endcase
		end
	end

	shp_next u_next (
		.state      (state_q),
		.max_speed  (max_speed_q),
		.max_target (max_target_q),
		.cmd        (cmd_s1),
		.state_next (state_next),
		.rsp        (rsp_next)
	);

	// State and result commit together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
